FILE: rtl/per_note_max_velocity_merge_defines.svh
// ---------------------------------------------------------------------------
// per_note_max_velocity_merge_defines
// assertion macros used by the per-note max velocity merge engine
// ---------------------------------------------------------------------------
`ifndef PER_NOTE_MAX_VELOCITY_MERGE_DEFINES_SVH
`define PER_NOTE_MAX_VELOCITY_MERGE_DEFINES_SVH

// same-cycle implication
`define PNMV_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define PNMV_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/pnmv_pkg.sv
// ---------------------------------------------------------------------------
// pnmv_pkg
// sizes, register codes, state codes and shared types of the velocity merge
// ---------------------------------------------------------------------------
package pnmv_pkg;

   // storage geometry
   localparam int MAX_NOTES  = 256;
   localparam int MAX_STOPS  = 16;
   localparam int NOTE_AW    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int STOP_AW    = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int PAIR_AW    = NOTE_AW + STOP_AW;
   localparam int LIM_W      = $clog2(MAX_STOPS + 1);

   // field and register widths
   localparam int NOTE_W     = 8;
   localparam int STOP_W     = 4;
   localparam int VEL_W      = 7;
   localparam int PCNT_W     = 9;
   localparam int SCNT_W     = 5;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [PCNT_W-1:0] PIPE_COUNT_RST = 9'd256;
   localparam logic [SCNT_W-1:0] STOP_COUNT_RST = 5'd1;

   typedef enum logic [0:0] {
      REG_PIPE_COUNT = 1'b0,
      REG_STOP_COUNT = 1'b1
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_EMIT
   } eng_state_type;

   typedef struct packed {
      logic [PCNT_W-1:0] pipe_count;
      logic [SCNT_W-1:0] stop_count;
   } cfg_type;

endpackage

FILE: rtl/pnmv_channels.sv
// ---------------------------------------------------------------------------
// pnmv_channels
// valid/ready channels for velocity beats and pipe drive beats
// ---------------------------------------------------------------------------
interface pnmv_req_if;
   import pnmv_pkg::*;

   logic              valid;
   logic              ready;
   logic [NOTE_W-1:0] note;
   logic [STOP_W-1:0] stop_index;
   logic [VEL_W-1:0]  velocity;

   modport source (output valid, output note, output stop_index, output velocity,
                   input ready);
   modport sink   (input valid, input note, input stop_index, input velocity,
                   output ready);
endinterface

interface pnmv_rsp_if;
   import pnmv_pkg::*;

   logic              valid;
   logic              ready;
   logic [NOTE_W-1:0] pipe_note;
   logic [VEL_W-1:0]  pipe_velocity;

   modport source (output valid, output pipe_note, output pipe_velocity, input ready);
   modport sink   (input valid, input pipe_note, input pipe_velocity, output ready);
endinterface

FILE: rtl/per_note_max_velocity_merge.sv
// ---------------------------------------------------------------------------
// per_note_max_velocity_merge
// keeps per (note, stop) velocities and drives each pipe at the stop maximum
// ---------------------------------------------------------------------------
// Each req beat sets the velocity of one stop on one note; the block stores it
// and, whenever the note's maximum over all stops in use changes or may have
// dropped, sends a rsp beat with the note and its new maximum. Beats whose note
// is at or above pipe_count, or whose stop is at or above stop_count, are
// dropped with no effect. After reset the block first sweeps both memories to
// zero, one stop entry per cycle over all 4096 entries, and takes no req beat
// meanwhile (register writes are taken as usual). Beats are handled one at a
// time: a dropped beat ends in idle, one that leaves the maximum alone ends
// after the lookup, a raise of the maximum goes from lookup to emit, and a
// decrease of a stop below the maximum rescans the note's stops via the single
// read port of the stop memory, up to lim = min(stop_count, 16) stops, before
// emit. A finished rsp beat sits in an output register, so the next req beat
// is taken while it waits; a beat that needs to emit while that register is
// still full holds until the receiver takes the waiting one.
// Registers: pipe_count at byte 0, reset 256; stop_count at byte 4, reset 1.
module per_note_max_velocity_merge (
   input  logic                      clock,
   input  logic                      reset,
   pnmv_req_if.sink                  req_if,
   pnmv_rsp_if.source                rsp_if,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [pnmv_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [pnmv_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [pnmv_pkg::CSR_DW-1:0] csr_prdata,
   output logic                      csr_pready
);
   import pnmv_pkg::*;

   // live configuration toward the engine
   cfg_type cfg;

   // register file
   pnmv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // memory sequencer: lookup, write back, rescan and result register
   pnmv_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

FILE: rtl/pnmv_csr.sv
// ---------------------------------------------------------------------------
// pnmv_csr
// apb register file holding pipe_count and stop_count
// ---------------------------------------------------------------------------
module pnmv_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [pnmv_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [pnmv_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [pnmv_pkg::CSR_DW-1:0] csr_prdata,
   output logic                      csr_pready,
   output pnmv_pkg::cfg_type         cfg
);
   import pnmv_pkg::*;

   logic [PCNT_W-1:0] pipe_count_ff, pipe_count_in;
   logic [SCNT_W-1:0] stop_count_ff, stop_count_in;
   reg_idx_type       reg_idx;
   logic              wr_en;

   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      pipe_count_in = pipe_count_ff;
      stop_count_in = stop_count_ff;
      csr_prdata    = '0;
      case (reg_idx)
         REG_PIPE_COUNT: begin
            csr_prdata = CSR_DW'(pipe_count_ff);
            if (wr_en) begin
               pipe_count_in = csr_pwdata[PCNT_W-1:0];
            end
         end
         REG_STOP_COUNT: begin
            csr_prdata = CSR_DW'(stop_count_ff);
            if (wr_en) begin
               stop_count_in = csr_pwdata[SCNT_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_count_ff <= PIPE_COUNT_RST;
         stop_count_ff <= STOP_COUNT_RST;
      end else begin
         pipe_count_ff <= pipe_count_in;
         stop_count_ff <= stop_count_in;
      end
   end

   assign cfg.pipe_count = pipe_count_ff;
   assign cfg.stop_count = stop_count_ff;

endmodule

FILE: rtl/pnmv_engine.sv
// ---------------------------------------------------------------------------
// pnmv_engine
// read-modify-write sequencer over the stop velocity and note maximum memories
// ---------------------------------------------------------------------------
`include "per_note_max_velocity_merge_defines.svh"

module pnmv_engine (
   input  logic              clock,
   input  logic              reset,
   input  pnmv_pkg::cfg_type cfg,
   pnmv_req_if.sink          req_if,
   pnmv_rsp_if.source        rsp_if
);
   import pnmv_pkg::*;

   localparam int PAIR_DEPTH = 1 << PAIR_AW;

   eng_state_type     state_ff, state_in;
   logic [PAIR_AW-1:0] clr_ff, clr_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [STOP_W-1:0] stop_ff, stop_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;
   logic [LIM_W-1:0]  lim_ff, lim_in;
   logic [LIM_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [VEL_W-1:0]  best_ff, best_in;
   logic [VEL_W-1:0]  res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NOTE_W-1:0] rsp_note_ff, rsp_note_in;
   logic [VEL_W-1:0]  rsp_vel_ff, rsp_vel_in;

   // memories and their ports
   logic [VEL_W-1:0]   pair_mem [PAIR_DEPTH];
   logic [VEL_W-1:0]   max_mem  [MAX_NOTES];
   logic [VEL_W-1:0]   pair_rd_ff;
   logic [VEL_W-1:0]   max_rd_ff;
   logic               pair_we;
   logic [PAIR_AW-1:0] pair_waddr;
   logic [VEL_W-1:0]   pair_wdata;
   logic [PAIR_AW-1:0] pair_raddr;
   logic               max_we;
   logic [NOTE_AW-1:0] max_waddr;
   logic [VEL_W-1:0]   max_wdata;
   logic [NOTE_AW-1:0] max_raddr;

   logic               accept;
   logic               in_range;
   logic               slot_free;
   logic [LIM_W-1:0]   lim_cfg;
   logic [NOTE_AW-1:0] clr_note;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign clr_note     = clr_ff[PAIR_AW-1:STOP_AW];

   assign in_range = (PCNT_W'(req_if.note) < cfg.pipe_count)
                  && (int'(req_if.note) < MAX_NOTES)
                  && (SCNT_W'(req_if.stop_index) < cfg.stop_count)
                  && (int'(req_if.stop_index) < MAX_STOPS);

   assign lim_cfg = (int'(cfg.stop_count) >= MAX_STOPS) ? LIM_W'(MAX_STOPS)
                                                        : LIM_W'(cfg.stop_count);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      note_in      = note_ff;
      stop_in      = stop_ff;
      vel_in       = vel_ff;
      lim_in       = lim_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      best_in      = best_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_note_in  = rsp_note_ff;
      rsp_vel_in   = rsp_vel_ff;
      pair_we      = 1'b0;
      pair_waddr   = {NOTE_AW'(note_ff), STOP_AW'(stop_ff)};
      pair_wdata   = vel_ff;
      pair_raddr   = {NOTE_AW'(req_if.note), STOP_AW'(req_if.stop_index)};
      max_we       = 1'b0;
      max_waddr    = NOTE_AW'(note_ff);
      max_wdata    = vel_ff;
      max_raddr    = NOTE_AW'(req_if.note);

      case (state_ff)
         ST_CLEAR: begin
            pair_we    = 1'b1;
            pair_waddr = clr_ff;
            pair_wdata = '0;
            max_we     = (int'(clr_note) < MAX_NOTES);
            max_waddr  = clr_note;
            max_wdata  = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == PAIR_AW'(PAIR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && in_range) begin
               note_in  = req_if.note;
               stop_in  = req_if.stop_index;
               vel_in   = req_if.velocity;
               lim_in   = lim_cfg;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // pair entry always takes the new velocity
            pair_we = 1'b1;
            if ((pair_rd_ff <= vel_ff) && (vel_ff <= max_rd_ff)) begin
               state_in = ST_IDLE;
            end else if (vel_ff >= max_rd_ff) begin
               max_we   = 1'b1;
               res_in   = vel_ff;
               state_in = ST_EMIT;
            end else begin
               scan_in  = '0;
               best_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pair_raddr = {NOTE_AW'(note_ff), STOP_AW'(scan_ff)};
            if (scan_ff < lim_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff && (pair_rd_ff > best_ff)) begin
               best_in = pair_rd_ff;
            end
            if (!pend_ff && (scan_ff >= lim_ff)) begin
               max_we    = 1'b1;
               max_wdata = best_ff;
               res_in    = best_ff;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_note_in  = note_ff;
               rsp_vel_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff     <= note_in;
      stop_ff     <= stop_in;
      vel_ff      <= vel_in;
      lim_ff      <= lim_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
      rsp_note_ff <= rsp_note_in;
      rsp_vel_ff  <= rsp_vel_in;
   end

   // stop velocity memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (pair_we) begin
         pair_mem[pair_waddr] <= pair_wdata;
      end
      pair_rd_ff <= pair_mem[pair_raddr];
   end

   // note maximum memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (max_we) begin
         max_mem[max_waddr] <= max_wdata;
      end
      max_rd_ff <= max_mem[max_raddr];
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.pipe_note     = rsp_note_ff;
   assign rsp_if.pipe_velocity = rsp_vel_ff;

   `PNMV_ASSERT_NOW(a_scan_bound, clock, reset, state_ff == ST_SCAN, scan_ff <= lim_ff, "scan past stop limit")
   `PNMV_ASSERT_NOW(a_pend_in_scan, clock, reset, pend_ff, state_ff == ST_SCAN, "read pending outside scan")
   `PNMV_ASSERT_NOW(a_look_after_idle, clock, reset, state_ff == ST_LOOK, $past(state_ff) == ST_IDLE, "lookup not started from idle")
   `PNMV_ASSERT_NEXT(a_emit_loads, clock, reset, state_ff == ST_EMIT && slot_free, rsp_valid_ff && state_ff == ST_IDLE, "emit did not load result")

endmodule

FILE: tb/per_note_max_velocity_merge_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// per_note_max_velocity_merge_tb
// self-checking bench for the per-note max velocity merge: directed corner
// beats, then phased random key traffic under changing pipe and stop counts,
// with every pipe drive beat compared against a tracked copy of both stores
// ---------------------------------------------------------------------------
module per_note_max_velocity_merge_tb;
   import pnmv_pkg::*;

   // consecutive cycles with no accepted beat before the run is called hung;
   // the post-reset clear sweep alone covers all 4096 stop entries
   localparam int WATCHDOG_LIMIT = 20000;
   // longest beat is a decrease with a full rescan, keep margin
   localparam int SETTLE_CYCLES  = 30;
   localparam int TAIL_CYCLES    = 40;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int PHASES         = 8;

   typedef struct packed {
      logic [NOTE_W-1:0] pipe_note;
      logic [VEL_W-1:0]  pipe_velocity;
   } pipe_drive_type;

   // tracks both velocity stores and the pipe drive beats they imply
   class pipe_drive_tracker;
      logic [VEL_W-1:0] stop_vel [MAX_NOTES][MAX_STOPS];
      logic [VEL_W-1:0] note_max [MAX_NOTES];
      int unsigned      pipe_count;
      int unsigned      stop_count;
      pipe_drive_type   due_drives[$];
      int unsigned      mismatches;

      function new();
         foreach (stop_vel[n, s]) stop_vel[n][s] = '0;
         foreach (note_max[n]) note_max[n] = '0;
         pipe_count = 32'(PIPE_COUNT_RST);
         stop_count = 32'(STOP_COUNT_RST);
         mismatches = 0;
      endfunction

      function void set_reg(input reg_idx_type idx, input logic [CSR_DW-1:0] value);
         case (idx)
            REG_PIPE_COUNT: pipe_count = 32'(value[PCNT_W-1:0]);
            REG_STOP_COUNT: stop_count = 32'(value[SCNT_W-1:0]);
            default: ;
         endcase
      endfunction

      // one accepted key beat: update the stores, queue a drive if the max may have moved
      function void take_key_beat(input logic [NOTE_W-1:0] n, input logic [STOP_W-1:0] s,
                                  input logic [VEL_W-1:0] v);
         int unsigned      lim;
         logic [VEL_W-1:0] old_vel;
         logic [VEL_W-1:0] peak;
         pipe_drive_type   drive;
         if (n >= pipe_count || n >= MAX_NOTES || s >= stop_count || s >= MAX_STOPS)
            return;
         old_vel = stop_vel[n][s];
         peak = note_max[n];
         stop_vel[n][s] = v;
         if (old_vel <= v && v <= peak)
            return;
         if (v >= peak) begin
            peak = v;
         end else begin
            // max may have dropped: rescan the stops in use
            lim = (stop_count < MAX_STOPS) ? stop_count : MAX_STOPS;
            peak = '0;
            for (int k = 0; k < lim; k++)
               if (stop_vel[n][k] > peak) peak = stop_vel[n][k];
         end
         note_max[n] = peak;
         drive.pipe_note = n;
         drive.pipe_velocity = peak;
         due_drives = {due_drives, drive};
      endfunction

      function void match_pipe_beat(input logic [NOTE_W-1:0] n, input logic [VEL_W-1:0] v);
         pipe_drive_type want;
         if (due_drives.size() == 0) begin
            $error("pipe drive beat with nothing due: pipe_note %0d pipe_velocity %0d", n, v);
            mismatches++;
            return;
         end
         want = due_drives.pop_front();
         if (n !== want.pipe_note) begin
            $error("pipe_note: expected %0d, actual %0d", want.pipe_note, n);
            mismatches++;
         end
         if (v !== want.pipe_velocity) begin
            $error("pipe_velocity: expected %0d, actual %0d", want.pipe_velocity, v);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pnmv_req_if req_ch ();
   pnmv_rsp_if rsp_ch ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   pipe_drive_tracker tracker;
   int unsigned       quiet_cycles = 0;

   per_note_max_velocity_merge dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // drive helpers: everything changes at the falling edge, handshakes are
   // sampled at the rising edge
   // ---------------------------------------------------------------------

   // present one key beat and hold it until the block takes it
   task automatic send_key(input logic [NOTE_W-1:0] n, input logic [STOP_W-1:0] s,
                           input logic [VEL_W-1:0] v);
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.note       = n;
      req_ch.stop_index = s;
      req_ch.velocity   = v;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      tracker.take_key_beat(n, s, v);
   endtask

   // sender gap of a given number of cycles
   task automatic go_quiet(input int unsigned cycles);
      @(negedge clock);
      req_ch.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop sending, let every due drive beat come out, then let a trailing
   // beat that produces nothing finish inside the block
   task automatic drain_and_settle();
      go_quiet(1);
      while (tracker.due_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input reg_idx_type idx, input int unsigned value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_AW'({idx, 2'b00});
      csr_pwdata  = CSR_DW'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      tracker.set_reg(idx, CSR_DW'(value));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic configure(input int unsigned pipes, input int unsigned stops);
      csr_write(REG_PIPE_COUNT, pipes);
      csr_write(REG_STOP_COUNT, stops);
   endtask

   // random key beat: mostly in range and clustered on a few notes so that
   // holds, raises and rescans all happen often; the rest is noise and
   // deliberately out-of-range notes or stops
   task automatic pick_key(output logic [NOTE_W-1:0] n, output logic [STOP_W-1:0] s,
                           output logic [VEL_W-1:0] v);
      int unsigned roll;
      int unsigned pc;
      int unsigned sc;
      int unsigned hot;
      pc = tracker.pipe_count;
      sc = tracker.stop_count;
      roll = $urandom_range(0, 99);
      n = NOTE_W'($urandom_range(0, 255));
      s = STOP_W'($urandom_range(0, 15));
      v = VEL_W'($urandom_range(0, 127));
      if (roll < 8)
         return;
      if (roll < 15) begin
         if (pc < MAX_NOTES && (sc >= MAX_STOPS || $urandom_range(0, 1) == 1))
            n = NOTE_W'($urandom_range(pc, 255));
         else if (sc < MAX_STOPS)
            s = STOP_W'($urandom_range(sc, 15));
         return;
      end
      hot = (pc < 6) ? pc : 6;
      n = ($urandom_range(0, 3) != 0) ? NOTE_W'($urandom_range(0, hot - 1))
                                      : NOTE_W'($urandom_range(0, pc - 1));
      s = STOP_W'($urandom_range(0, sc - 1));
      case ($urandom_range(0, 6))
         0: v = '0;                                  // key off
         1: v = '1;                                  // full velocity
         2: v = tracker.note_max[n];                 // tie with the max
         3: v = VEL_W'($urandom_range(0, tracker.note_max[n]));
         4: v = tracker.stop_vel[n][s];              // repeat of the stored value
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // receiver: ready follows a pattern, picked anew at random, that goes
   // from always ready through random to long periodic stalls
   // ---------------------------------------------------------------------
   initial begin
      int unsigned mode;
      int unsigned span;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 160);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = 1'($urandom_range(0, 1));
               2: rsp_ch.ready = ((k % 16) >= 10);      // periodic stall, then ready
               default: rsp_ch.ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // every accepted pipe drive beat is checked against the oldest due one
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.match_pipe_beat(rsp_ch.pipe_note, rsp_ch.pipe_velocity);
   end

   // watchdog: too long without any accepted beat means the block is hung
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned       burst_left;
      int unsigned       gap;
      int unsigned       phase_pipes;
      int unsigned       phase_stops;
      bit                steady;
      logic [NOTE_W-1:0] n;
      logic [STOP_W-1:0] s;
      logic [VEL_W-1:0]  v;

      tracker = new();
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.note       = '0;
      req_ch.stop_index = '0;
      req_ch.velocity   = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset register values: one stop, so stop 1 is dropped; these beats
      // also wait out the clear sweep
      send_key(8'd5, 4'd0, 7'd90);
      send_key(8'd5, 4'd1, 7'd90);
      drain_and_settle();

      // all stops, all notes: raise, hold, decrease with rescan
      configure(256, 16);
      send_key(8'd0, 4'd0, 7'd127);      // raise to full
      send_key(8'd0, 4'd1, 7'd100);      // below max, no beat
      send_key(8'd0, 4'd0, 7'd0);        // max stop released, rescan finds 100
      send_key(8'd0, 4'd1, 7'd50);       // lower than stored, rescan gives 50
      send_key(8'd255, 4'd15, 7'd127);   // top note, top stop
      send_key(8'd255, 4'd15, 7'd127);   // same value again, no beat
      send_key(8'd255, 4'd15, 7'd0);     // off, rescan to zero
      send_key(8'd255, 4'd0, 7'd0);      // zero on zero, no beat
      send_key(8'd17, 4'd3, 7'd64);
      send_key(8'd17, 4'd7, 7'd64);      // tie with max, no beat
      send_key(8'd17, 4'd3, 7'd1);       // rescan keeps 64
      send_key(8'd17, 4'd7, 7'd127);
      send_key(8'd17, 4'd7, 7'd64);
      drain_and_settle();

      // one note, one stop: everything else is dropped
      configure(1, 1);
      send_key(8'd0, 4'd0, 7'd5);        // under max 50, no beat
      send_key(8'd0, 4'd0, 7'd3);        // rescan sees stop 0 only
      send_key(8'd1, 4'd0, 7'd9);        // note out of range
      send_key(8'd255, 4'd15, 7'd127);   // both out of range
      send_key(8'd0, 4'd15, 7'd9);       // stop out of range
      send_key(8'd0, 4'd1, 7'd9);
      drain_and_settle();

      // widen again: the hidden stop 1 entry comes back into the rescan
      configure(256, 16);
      send_key(8'd0, 4'd0, 7'd2);
      send_key(8'd0, 4'd1, 7'd0);

      // random phases, each under its own pipe and stop counts; the drain
      // between phases is also the full sender pause
      for (int p = 0; p < PHASES; p++) begin
         steady = 1'b0;
         case (p)
            0: begin phase_pipes = 256; phase_stops = 16; end
            1: begin phase_pipes = 1;   phase_stops = 1;  end
            2: begin phase_pipes = 256; phase_stops = 1; steady = 1'b1; end
            3: begin phase_pipes = 1;   phase_stops = 16; end
            5: begin phase_pipes = 4;   phase_stops = 3;  end
            7: begin phase_pipes = 256; phase_stops = 16; steady = 1'b1; end
            default: begin
               phase_pipes = $urandom_range(1, 256);
               phase_stops = $urandom_range(1, 16);
            end
         endcase
         drain_and_settle();
         configure(phase_pipes, phase_stops);
         burst_left = 0;
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            // bursts of beats separated by gaps, mostly short, now and then long, none when steady
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (steady)
                  gap = 0;
               else if ($urandom_range(0, 9) == 0)
                  gap = $urandom_range(10, 40);
               else
                  gap = $urandom_range(0, 4);
               if (gap != 0) go_quiet(gap);
            end
            burst_left--;
            pick_key(n, s, v);
            send_key(n, s, v);
         end
      end

      // wait for every due drive beat, then watch a while for strays
      go_quiet(1);
      while (tracker.due_drives.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.due_drives.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
